// ===== rtl/core/bldc_olc_pkg.sv =====
// ----------------------------------------------------------------------------
// BLDC open-loop commutator package
// Shared types, register indexes, reset values and helper functions.
// ----------------------------------------------------------------------------
package bldc_olc_pkg;

   // Register indexes on the configuration port (byte address / 4).
   localparam logic [2:0] REG_TURN_DIRECTION     = 3'd0;
   localparam logic [2:0] REG_RAMP_TARGET_LEVEL  = 3'd1;
   localparam logic [2:0] REG_START_INTERVAL     = 3'd2;
   localparam logic [2:0] REG_SHORTEST_INTERVAL  = 3'd3;
   localparam logic [2:0] REG_INTERVAL_DECREMENT = 3'd4;

   // Direction codes; any other code means stop.
   localparam logic [1:0] DIR_FORWARD = 2'd0;
   localparam logic [1:0] DIR_REVERSE = 2'd1;

   // Last valid rotor position of the six-step sequence.
   localparam logic [2:0] POS_LAST = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [1:0]  TURN_DIRECTION_RESET     = DIR_FORWARD;
   localparam logic [7:0]  RAMP_TARGET_RESET        = 8'd30;
   localparam logic [15:0] START_INTERVAL_RESET     = 16'd800;
   localparam logic [15:0] SHORTEST_INTERVAL_RESET  = 16'd150;
   localparam logic [15:0] INTERVAL_DECREMENT_RESET = 16'd2;

   typedef struct packed {
      logic [1:0]  turn_direction;
      logic [7:0]  ramp_target_level;
      logic [15:0] start_interval;
      logic [15:0] shortest_interval;
      logic [15:0] interval_decrement;
   } cfg_type;

   // A write of the start interval reloads the interval and clears the count.
   typedef struct packed {
      logic        load;
      logic [15:0] value;
   } reload_type;

   typedef struct packed {
      logic [5:0] gate_enable_pattern;
      logic [7:0] duty_level;
      logic       commutated;
      logic [2:0] rotor_step;
   } rsp_type;

   // Shorten an interval by the decrement, never going below the floor.
   function automatic logic [15:0] shorten(input logic [15:0] len,
                                           input logic [15:0] dec,
                                           input logic [15:0] floor_len);
      logic [15:0] diff;
      diff = len - dec;
      if ((len > dec) && (diff > floor_len)) begin
         return diff;
      end
      return floor_len;
   endfunction

   // Gate enables for each rotor position; unused codes switch everything off.
   function automatic logic [5:0] step_pattern(input logic [2:0] pos);
      logic [5:0] pat;
      case (pos)
         3'd0:    pat = 6'b001001;
         3'd1:    pat = 6'b100001;
         3'd2:    pat = 6'b100100;
         3'd3:    pat = 6'b000110;
         3'd4:    pat = 6'b010010;
         3'd5:    pat = 6'b011000;
         default: pat = 6'b000000;
      endcase
      return pat;
   endfunction

   localparam logic [15:0] INTERVAL_RESET =
      shorten(START_INTERVAL_RESET, INTERVAL_DECREMENT_RESET, SHORTEST_INTERVAL_RESET);

endpackage

// ===== rtl/core/bldc_olc_csr.sv =====
// ----------------------------------------------------------------------------
// BLDC open-loop commutator configuration registers
// APB-style register file holding direction, ramp target and interval set-up.
// ----------------------------------------------------------------------------
module bldc_olc_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [4:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready,
   output bldc_olc_pkg::cfg_type    cfg,
   output bldc_olc_pkg::reload_type reload
);
   import bldc_olc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_en     = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_TURN_DIRECTION:     cfg_in.turn_direction     = pwdata[1:0];
            REG_RAMP_TARGET_LEVEL:  cfg_in.ramp_target_level  = pwdata[7:0];
            REG_START_INTERVAL:     cfg_in.start_interval     = pwdata[15:0];
            REG_SHORTEST_INTERVAL:  cfg_in.shortest_interval  = pwdata[15:0];
            REG_INTERVAL_DECREMENT: cfg_in.interval_decrement = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.turn_direction     <= TURN_DIRECTION_RESET;
         cfg_ff.ramp_target_level  <= RAMP_TARGET_RESET;
         cfg_ff.start_interval     <= START_INTERVAL_RESET;
         cfg_ff.shortest_interval  <= SHORTEST_INTERVAL_RESET;
         cfg_ff.interval_decrement <= INTERVAL_DECREMENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_TURN_DIRECTION:     prdata = {30'd0, cfg_ff.turn_direction};
         REG_RAMP_TARGET_LEVEL:  prdata = {24'd0, cfg_ff.ramp_target_level};
         REG_START_INTERVAL:     prdata = {16'd0, cfg_ff.start_interval};
         REG_SHORTEST_INTERVAL:  prdata = {16'd0, cfg_ff.shortest_interval};
         REG_INTERVAL_DECREMENT: prdata = {16'd0, cfg_ff.interval_decrement};
         default:                prdata = 32'd0;
      endcase
   end

   assign cfg          = cfg_ff;
   assign reload.load  = wr_en && (reg_index == REG_START_INTERVAL);
   assign reload.value = pwdata[15:0];

endmodule

// ===== rtl/core/bldc_olc_step.sv =====
// ----------------------------------------------------------------------------
// BLDC open-loop commutator step unit
// Holds the commutation state; updates it on each advanced request or a reload.
// ----------------------------------------------------------------------------
module bldc_olc_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     tick,
   input  bldc_olc_pkg::cfg_type    cfg,
   input  bldc_olc_pkg::reload_type reload,
   output bldc_olc_pkg::rsp_type    rsp
);
   import bldc_olc_pkg::*;

   logic [7:0]  drive_ff,     drive_in;
   logic [15:0] interval_ff,  interval_in;
   logic [15:0] elapsed_ff,   elapsed_in;
   logic [2:0]  position_ff,  position_in;
   logic [5:0]  pattern_ff,   pattern_in;
   logic [7:0]  duty_ff,      duty_in;
   logic        commutated_ff, commutated_in;

   logic [15:0] elapsed_inc;
   logic [8:0]  drive_up;
   logic        hit;

   always_comb begin
      elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
      hit         = tick && (elapsed_inc >= interval_ff);
      drive_up    = {1'b0, drive_ff} + 9'd1;

      drive_in      = drive_ff;
      interval_in   = interval_ff;
      elapsed_in    = elapsed_ff;
      position_in   = position_ff;
      pattern_in    = pattern_ff;
      duty_in       = duty_ff;
      commutated_in = commutated_ff;

      if (reload.load) begin
         // User writes configuration only while idle (unenforced); reload wins.
         interval_in = shorten(reload.value, cfg.interval_decrement,
                               cfg.shortest_interval);
         elapsed_in  = 16'd0;
      end else if (advance) begin
         commutated_in = hit;
         if (tick) begin
            elapsed_in = hit ? 16'd0 : elapsed_inc;
         end
         if (hit) begin
            pattern_in = step_pattern(position_ff);
            case (cfg.turn_direction)
               DIR_FORWARD: position_in = (position_ff >= POS_LAST) ? 3'd0
                                                                   : position_ff + 3'd1;
               DIR_REVERSE: position_in = ((position_ff == 3'd0) || (position_ff > POS_LAST))
                                          ? POS_LAST : position_ff - 3'd1;
               default:     position_in = 3'd0;
            endcase
            duty_in  = ((cfg.turn_direction == DIR_FORWARD) ||
                        (cfg.turn_direction == DIR_REVERSE)) ? drive_ff : 8'd0;
            drive_in = (drive_up < {1'b0, cfg.ramp_target_level}) ? drive_up[7:0]
                                                                   : cfg.ramp_target_level;
            interval_in = shorten(interval_ff, cfg.interval_decrement,
                                  cfg.shortest_interval);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff    <= 8'd0;
         interval_ff <= INTERVAL_RESET;
         elapsed_ff  <= 16'd0;
         position_ff <= 3'd0;
         pattern_ff  <= 6'd0;
         duty_ff     <= 8'd0;
      end else begin
         drive_ff    <= drive_in;
         interval_ff <= interval_in;
         elapsed_ff  <= elapsed_in;
         position_ff <= position_in;
         pattern_ff  <= pattern_in;
         duty_ff     <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      commutated_ff <= commutated_in;
   end

   assign rsp.gate_enable_pattern = pattern_ff;
   assign rsp.duty_level          = duty_ff;
   assign rsp.commutated          = commutated_ff;
   assign rsp.rotor_step          = position_ff;

endmodule

// ===== rtl/core/bldc_olc_top.sv =====
// ----------------------------------------------------------------------------
// BLDC open-loop commutator top level
// Six-step open-loop start-up sequencer for a three-phase BLDC bridge.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_stall  tick
//  rsp_      out        rsp_valid/rsp_stall  gate_enable_pattern, duty_level,
//                                            commutated, rotor_step
//  APB       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One request is accepted per clock while req_stall is low; each request yields exactly one
// response, the path being one input register and one result register.
// The limiting loop is the state update in the step unit.
// Reset is synchronous and active high; it restores the register defaults
// and sets the interval to the start interval less one decrement.
// A stalled response holds its register; the input register keeps accepting
// while the response side drains, and req_stall rises only when both are full.
// ----------------------------------------------------------------------------
module bldc_open_loop_commutator_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_tick,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_gate_enable_pattern,
   output logic [7:0]  rsp_duty_level,
   output logic        rsp_commutated,
   output logic [2:0]  rsp_rotor_step,
   // Configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bldc_olc_pkg::*;

   cfg_type    cfg;
   reload_type reload;
   rsp_type    rsp;

   logic in_valid_ff, in_valid_in;
   logic in_tick_ff;
   logic out_valid_ff, out_valid_in;
   logic advance;
   logic req_take;

   // The held request moves into the state update whenever the result
   // register is empty or its current contents are being taken this cycle.
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      in_valid_in  = req_take | (in_valid_ff & ~advance);
      out_valid_in = advance | (out_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // The request payload only changes when a new request is taken.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_tick_ff <= req_tick;
      end
   end

   bldc_olc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .reload  (reload)
   );

   bldc_olc_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tick    (in_tick_ff),
      .cfg     (cfg),
      .reload  (reload),
      .rsp     (rsp)
   );

   assign rsp_valid               = out_valid_ff;
   assign rsp_gate_enable_pattern = rsp.gate_enable_pattern;
   assign rsp_duty_level          = rsp.duty_level;
   assign rsp_commutated          = rsp.commutated;
   assign rsp_rotor_step          = rsp.rotor_step;

endmodule
